// ===== rtl/fixed_point_freeverb_reverb_unit_macros.svh =====
// Assertion macros shared by the reverb unit RTL.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef FIXED_POINT_FREEVERB_REVERB_UNIT_MACROS_SVH
`define FIXED_POINT_FREEVERB_REVERB_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FPFR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define FPFR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fpfr_pkg.sv =====
// Package for the reverb unit: configuration struct, sequencer states,
// filter length tables and the saturation helper. No dependencies.
package fpfr_pkg;

  localparam int COMB_COUNT    = 8;
  localparam int ALLPASS_COUNT = 4;
  localparam int COMB_TOTAL    = 11024;
  localparam int AP_TOTAL      = 1563;

  // register indexes on the configuration port
  localparam logic [2:0] REG_FEEDBACK = 3'd0;
  localparam logic [2:0] REG_DAMPING  = 3'd1;
  localparam logic [2:0] REG_DRY      = 3'd2;
  localparam logic [2:0] REG_WET      = 3'd3;
  localparam logic [2:0] REG_STEREO   = 3'd4;
  localparam logic [2:0] REG_SCALE    = 3'd5;

  // gains and fixed scalers
  localparam logic signed [15:0] IN_GAIN  = 16'sd8738;
  localparam logic signed [15:0] SUM_GAIN = 16'sd31457;

  typedef logic [10:0] comb_pos_t;
  typedef logic [9:0]  ap_pos_t;

  localparam comb_pos_t COMB_LEN [COMB_COUNT] = '{
    11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617};
  localparam logic [13:0] COMB_BASE [COMB_COUNT] = '{
    14'd0, 14'd1116, 14'd2304, 14'd3581, 14'd4937, 14'd6359, 14'd7850, 14'd9407};
  localparam ap_pos_t AP_LEN [ALLPASS_COUNT] = '{10'd556, 10'd441, 10'd341, 10'd225};
  localparam logic [10:0] AP_BASE [ALLPASS_COUNT] = '{11'd0, 11'd556, 11'd997, 11'd1338};

  typedef struct packed {
    logic [14:0] feedback;
    logic [13:0] damping;
    logic [14:0] dry;
    logic [14:0] wet;
    logic        stereo;
    logic [15:0] scale;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_PRE,
    ST_C_RD, ST_C_MUL, ST_C_LP, ST_C_FB, ST_C_WR,
    ST_SUM, ST_O, ST_A_RD, ST_A_WR,
    ST_W30, ST_MIX1, ST_MIX2, ST_MIX3, ST_OUT
  } state_e;

  // clamp a shifted value to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/fpfr_ram.sv =====
// Generic single-port RAM with registered, read-first output.
// No dependencies.
module fpfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fpfr_ctrl.sv =====
// Sequencer and datapath: clears the delay stores, then runs the eight combs
// and four allpasses of one bank per word. Depends on fpfr_pkg and the macros.
`include "fixed_point_freeverb_reverb_unit_macros.svh"
module fpfr_ctrl #(
  parameter int MAX_CHANNELS = 2,
  localparam int CD   = MAX_CHANNELS * fpfr_pkg::COMB_TOTAL,
  localparam int AD   = MAX_CHANNELS * fpfr_pkg::AP_TOTAL,
  localparam int CA_W = $clog2(CD),
  localparam int AA_W = $clog2(AD)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpfr_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  input  logic [15:0]        in_data_i,
  output logic               in_ready_o,
  output logic               res_valid_o,
  output logic [15:0]        res_data_o,
  input  logic               res_ready_i,
  output logic               comb_we_o,
  output logic [CA_W-1:0]    comb_addr_o,
  output logic [15:0]        comb_wdata_o,
  input  logic [15:0]        comb_rdata_i,
  output logic               ap_we_o,
  output logic [AA_W-1:0]    ap_addr_o,
  output logic [15:0]        ap_wdata_o,
  input  logic [15:0]        ap_rdata_i
);
  import fpfr_pkg::*;

  localparam int NC   = MAX_CHANNELS * COMB_COUNT;
  localparam int NA   = MAX_CHANNELS * ALLPASS_COUNT;
  localparam int CK_W = $clog2(NC);
  localparam int AK_W = $clog2(NA);
  localparam int PW   = 37;

  state_e state_q, state_d;

  logic signed [15:0] x_q, in_q, lp_q, o_q;
  logic signed [18:0] sum_q;
  logic signed [20:0] w30_q;
  logic signed [16:0] w_q;
  logic signed [PW-1:0] pa_q, pb_q;
  logic [2:0]  j_q;
  logic        bank_q, chan_q;
  logic [CA_W-1:0] clr_q, ca_q;
  logic [AA_W-1:0] aa_q;
  logic signed [15:0] lp_arr [NC];
  comb_pos_t cpos [NC];
  ap_pos_t   apos [NA];

  logic [CK_W-1:0] kc;
  logic [AK_W-1:0] ka;
  logic [1:0]      ja;
  logic [CA_W-1:0] c_addr;
  logic [AA_W-1:0] a_addr;
  logic signed [15:0] y, b;
  logic signed [16:0] d2, scale_s;
  logic signed [15:0] d1, fb, dry, wet;
  logic signed [15:0] lp_new, comb_w, ap_w, o_new;
  logic clear_done, bank_sel;

  assign ja = j_q[1:0];
  assign kc = CK_W'({bank_q, j_q});
  assign ka = AK_W'({bank_q, ja});
  assign y  = $signed(comb_rdata_i);
  assign b  = $signed(ap_rdata_i);

  // gains as signed operands
  assign d1      = $signed({2'b00, cfg_i.damping});
  assign d2      = $signed(17'd32768 - {3'b000, cfg_i.damping});
  assign fb      = $signed({1'b0, cfg_i.feedback});
  assign dry     = $signed({1'b0, cfg_i.dry});
  assign wet     = $signed({1'b0, cfg_i.wet});
  assign scale_s = $signed({1'b0, cfg_i.scale});

  // store addresses: bank offset + line base + position
  assign c_addr = (bank_q ? CA_W'(COMB_TOTAL) : CA_W'(0)) + CA_W'(COMB_BASE[j_q])
                  + CA_W'(cpos[kc]);
  assign a_addr = (bank_q ? AA_W'(AP_TOTAL) : AA_W'(0)) + AA_W'(AP_BASE[ja])
                  + AA_W'(apos[ka]);

  assign lp_new = sat16(40'((pa_q + pb_q) >>> 15));
  assign comb_w = sat16(40'(in_q) + 40'(sat16(40'(pa_q >>> 15))));
  assign ap_w   = sat16(40'(o_q) + 40'(b >>> 1));
  assign o_new  = sat16(40'(17'(b) - 17'(o_q)) >>> 1);
  assign clear_done = (clr_q == CA_W'(CD - 1));
  assign bank_sel = cfg_i.stereo && (MAX_CHANNELS > 1) && chan_q;

  // next state and memory/handshake outputs
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    res_data_o   = sat16(40'(pa_q >>> 16));
    comb_we_o    = 1'b0;
    comb_addr_o  = ca_q;
    comb_wdata_o = comb_w;
    ap_we_o      = 1'b0;
    ap_addr_o    = aa_q;
    ap_wdata_o   = ap_w;
    unique case (state_q)
      ST_CLEAR: begin
        comb_we_o    = 1'b1;
        comb_addr_o  = clr_q;
        comb_wdata_o = '0;
        ap_we_o      = (clr_q < CA_W'(AD));
        ap_addr_o    = AA_W'(clr_q);
        ap_wdata_o   = '0;
        if (clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_PRE;
      end
      ST_PRE:   state_d = ST_C_RD;
      ST_C_RD: begin
        comb_addr_o = c_addr;
        state_d     = ST_C_MUL;
      end
      ST_C_MUL: state_d = ST_C_LP;
      ST_C_LP:  state_d = ST_C_FB;
      ST_C_FB:  state_d = ST_C_WR;
      ST_C_WR: begin
        comb_we_o = 1'b1;
        state_d   = (j_q == 3'(COMB_COUNT - 1)) ? ST_SUM : ST_C_RD;
      end
      ST_SUM:   state_d = ST_O;
      ST_O:     state_d = ST_A_RD;
      ST_A_RD: begin
        ap_addr_o = a_addr;
        state_d   = ST_A_WR;
      end
      ST_A_WR: begin
        ap_we_o = 1'b1;
        state_d = (ja == 2'(ALLPASS_COUNT - 1)) ? ST_W30 : ST_A_RD;
      end
      ST_W30:  state_d = ST_MIX1;
      ST_MIX1: state_d = ST_MIX2;
      ST_MIX2: state_d = ST_MIX3;
      ST_MIX3: state_d = ST_OUT;
      ST_OUT: begin
        res_valid_o = res_ready_i;
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  // control state: clear counter, channel, per-line positions and lowpass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      chan_q <= 1'b0;
      bank_q <= 1'b0;
      j_q    <= '0;
      for (int i = 0; i < NC; i++) begin
        cpos[i]   <= '0;
        lp_arr[i] <= '0;
      end
      for (int i = 0; i < NA; i++) apos[i] <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + CA_W'(1);
        ST_IDLE: begin
          if (in_valid_i) begin
            bank_q <= bank_sel;
            chan_q <= cfg_i.stereo ? !chan_q : 1'b0;
          end
        end
        ST_PRE: j_q <= '0;
        ST_C_LP: lp_arr[kc] <= lp_new;
        ST_C_WR: begin
          cpos[kc] <= (cpos[kc] == COMB_LEN[j_q] - 11'd1) ? '0 : cpos[kc] + 11'd1;
          j_q <= j_q + 3'd1;
        end
        ST_O: j_q <= '0;
        ST_A_WR: begin
          apos[ka] <= (apos[ka] == AP_LEN[ja] - 10'd1) ? '0 : apos[ka] + 10'd1;
          j_q <= j_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) x_q <= $signed(in_data_i);
        sum_q <= '0;
      end
      ST_PRE:  in_q <= sat16(40'((PW'(x_q) * PW'(IN_GAIN)) >>> 17));
      ST_C_RD: ca_q <= c_addr;
      ST_C_MUL: begin
        sum_q <= sum_q + 19'(y);
        pa_q  <= PW'(y) * PW'(d2);
        pb_q  <= PW'(lp_arr[kc]) * PW'(d1);
      end
      ST_C_LP: lp_q <= lp_new;
      ST_C_FB: pa_q <= PW'(lp_q) * PW'(fb);
      ST_SUM:  pa_q <= PW'(sum_q) * PW'(SUM_GAIN);
      ST_O:    o_q  <= sat16(40'(pa_q >>> 17));
      ST_A_RD: aa_q <= a_addr;
      ST_A_WR: o_q  <= o_new;
      ST_W30:  w30_q <= (21'(o_q) <<< 5) - (21'(o_q) <<< 1);
      ST_MIX1: begin
        pa_q <= PW'(w30_q) * PW'(wet);
        pb_q <= PW'(x_q) * PW'(dry);
      end
      ST_MIX2: w_q <= 17'(sat16(40'(pb_q >>> 15))) + 17'(sat16(40'(pa_q >>> 15)));
      ST_MIX3: pa_q <= PW'(w_q) * PW'(scale_s);
      default: ;
    endcase
  end

  `FPFR_ASSERT_NEXT(a_one_word, in_valid_i && in_ready_o, !in_ready_o, "second word taken while busy")
  `FPFR_ASSERT_IMP(a_res_room, res_valid_o, res_ready_i, "result shown with no room")
  `FPFR_ASSERT_IMP(a_comb_rmw, comb_we_o && state_q == ST_C_WR, $past(state_q) == ST_C_FB, "comb write out of sequence")
  `FPFR_ASSERT_IMP(a_ap_rmw, ap_we_o && state_q == ST_A_WR, $past(state_q) == ST_A_RD, "allpass write without read")

endmodule

// ===== rtl/fixed_point_freeverb_reverb_unit.sv =====
// Top level of the fixed-point reverb: configuration registers, delay store
// memories and output register. Depends on fpfr_pkg, fpfr_ctrl, fpfr_ram.
//
// Usage:
//  - s_axis_* carries one signed 16-bit sample per word; in stereo mode the
//    words alternate left, right, each channel with its own filter bank.
//  - m_axis_* returns one signed 16-bit reverberated sample per input word.
//  - cfg_we_i/cfg_index_i/cfg_wdata_i write one register per cycle; write
//    only while no sample is in flight.
//  - Each word keeps the unit busy until its result is handed off, so no
//    new word is taken before then: eight comb stages (read, multiply,
//    lowpass, feedback, write) and four allpass stages (read, write), each
//    a read-modify-write on the single port of its delay store, plus input
//    scale, mix and hand-off steps. The hand-off waits for a free output.
//  - After reset both delay stores are zeroed one entry per cycle;
//    s_axis_tready stays low during that pass. Registers return to their
//    reset values.
//  - If the receiver stalls, the finished sample waits in the output
//    register; the next input word is still taken and processed, and only
//    its result waits until the register is free.
module fixed_point_freeverb_reverb_unit #(
  parameter int MAX_CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import fpfr_pkg::*;

  localparam int CD   = MAX_CHANNELS * COMB_TOTAL;
  localparam int AD   = MAX_CHANNELS * AP_TOTAL;
  localparam int CA_W = $clog2(CD);
  localparam int AA_W = $clog2(AD);

  cfg_t cfg_q;
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        res_valid, res_ready;
  logic [15:0] res_data;
  logic            comb_we, ap_we;
  logic [CA_W-1:0] comb_addr;
  logic [AA_W-1:0] ap_addr;
  logic [15:0]     comb_wdata, comb_rdata, ap_wdata, ap_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feedback <= 15'd27524;
      cfg_q.damping  <= 14'd6553;
      cfg_q.dry      <= 15'd32767;
      cfg_q.wet      <= 15'd32767;
      cfg_q.stereo   <= 1'b0;
      cfg_q.scale    <= 16'd24575;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FEEDBACK: cfg_q.feedback <= cfg_wdata_i[14:0];
        REG_DAMPING:  cfg_q.damping  <= cfg_wdata_i[13:0];
        REG_DRY:      cfg_q.dry      <= cfg_wdata_i[14:0];
        REG_WET:      cfg_q.wet      <= cfg_wdata_i[14:0];
        REG_STEREO:   cfg_q.stereo   <= cfg_wdata_i[0];
        REG_SCALE:    cfg_q.scale    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (res_ready) out_valid_q <= res_valid;
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_data_q <= res_data;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  fpfr_ctrl #(.MAX_CHANNELS(MAX_CHANNELS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_data_i    (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .res_valid_o  (res_valid),
    .res_data_o   (res_data),
    .res_ready_i  (res_ready),
    .comb_we_o    (comb_we),
    .comb_addr_o  (comb_addr),
    .comb_wdata_o (comb_wdata),
    .comb_rdata_i (comb_rdata),
    .ap_we_o      (ap_we),
    .ap_addr_o    (ap_addr),
    .ap_wdata_o   (ap_wdata),
    .ap_rdata_i   (ap_rdata)
  );

  fpfr_ram #(.WIDTH(16), .DEPTH(CD)) u_comb_ram (
    .clk_i   (clk_i),
    .we_i    (comb_we),
    .addr_i  (comb_addr),
    .wdata_i (comb_wdata),
    .rdata_o (comb_rdata)
  );

  fpfr_ram #(.WIDTH(16), .DEPTH(AD)) u_ap_ram (
    .clk_i   (clk_i),
    .we_i    (ap_we),
    .addr_i  (ap_addr),
    .wdata_i (ap_wdata),
    .rdata_o (ap_rdata)
  );

endmodule

// ===== verif/tb_fixed_point_freeverb_reverb_unit.sv =====
// Self-checking testbench for fixed_point_freeverb_reverb_unit: drives samples
// and register writes, predicts each output sample. Depends on fpfr_pkg and the RTL.
module tb_fixed_point_freeverb_reverb_unit;
  import fpfr_pkg::*;

  localparam int NCH = 2;
  localparam int CMAX = 1617;
  localparam int AMAX = 556;
  localparam int CL [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
  localparam int AL [4] = '{556, 441, 341, 225};
  localparam logic [15:0] DIRECTED [11] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff,
    16'h0001, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h5555, 16'haaaa};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] sample_in
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] sample_out
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  fixed_point_freeverb_reverb_unit #(.MAX_CHANNELS(NCH)) u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  shortint comb_mem [NCH*8][CMAX];
  shortint ap_mem [NCH*4][AMAX];
  shortint comb_lp [NCH*8];
  int comb_pos [NCH*8];
  int ap_pos [NCH*4];
  bit chan;
  longint fb_g, damp_g, dry_g, wet_g, scale_g;
  bit stereo_g;

  logic [15:0] sample_q [$];     // words waiting for the driver
  logic [15:0] expected_q [$];   // predicted output samples
  int n_err = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic shortint clip(longint v, int s);
    longint r;
    r = v >>> s;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return shortint'(r);
  endfunction

  function automatic void reverb_reset();
    foreach (comb_mem[i, j]) comb_mem[i][j] = 0;
    foreach (ap_mem[i, j]) ap_mem[i][j] = 0;
    foreach (comb_lp[i]) begin
      comb_lp[i] = 0;
      comb_pos[i] = 0;
    end
    foreach (ap_pos[i]) ap_pos[i] = 0;
    chan = 0;
    fb_g = 27524; damp_g = 6553; dry_g = 32767; wet_g = 32767;
    stereo_g = 0; scale_g = 24575;
  endfunction

  function automatic logic [15:0] reverb_sample(logic [15:0] din);
    longint x, sum, w;
    shortint inp, y, o, b;
    int bank, k, p;
    x = longint'($signed(din));
    bank = stereo_g ? int'(chan) % NCH : 0;
    inp = clip(x * 8738, 17);
    sum = 0;
    for (int j = 0; j < 8; j++) begin
      k = bank * 8 + j;
      p = comb_pos[k];
      y = comb_mem[k][p];
      sum += y;
      comb_lp[k] = clip(longint'(y) * (32768 - damp_g) + longint'(comb_lp[k]) * damp_g, 15);
      comb_mem[k][p] = clip(longint'(inp) + clip(longint'(comb_lp[k]) * fb_g, 15), 0);
      comb_pos[k] = (p + 1 >= CL[j]) ? 0 : p + 1;
    end
    o = clip(sum * 31457, 17);
    for (int j = 0; j < 4; j++) begin
      k = bank * 4 + j;
      p = ap_pos[k];
      b = ap_mem[k][p];
      ap_mem[k][p] = clip(longint'(o) + asr(longint'(b), 1), 0);
      o = clip(longint'(b) - longint'(o), 1);
      ap_pos[k] = (p + 1 >= AL[j]) ? 0 : p + 1;
    end
    w = longint'(clip(x * dry_g, 15)) + longint'(clip(longint'(o) * 30 * wet_g, 15));
    chan = stereo_g ? ~chan : 1'b0;
    return clip(w * scale_g, 16);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
    n_err++;
  endtask

  // random gap: mostly short, sometimes long, often none
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // driver: the queue front is the word on the bus until it is taken
  int drv_gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_q.push_back(reverb_sample(s_axis_tdata));
      void'(sample_q.pop_front());
      drv_gap = gap_len();
    end
    if (s_axis_tvalid && !s_axis_tready) begin
    end else if (drv_gap > 0 || sample_q.size() == 0) begin
      if (drv_gap > 0) drv_gap--;
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= sample_q[0];
    end
  end

  // monitor with random receiver stalls
  int mon_gap = 0;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report("unexpected word", m_axis_tdata, 16'h0);
      end else begin
        logic [15:0] want;
        want = expected_q.pop_front();
        if (m_axis_tdata !== want) report("sample_out", m_axis_tdata, want);
      end
      mon_gap = gap_len();
    end
    if (mon_gap > 0) begin
      mon_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic wait_idle();
    while (sample_q.size() != 0 || expected_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // one write, then cfg_we_i low again before returning
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FEEDBACK: fb_g = val & 16'h7fff;
      REG_DAMPING: damp_g = val & 16'h3fff;
      REG_DRY: dry_g = val & 16'h7fff;
      REG_WET: wet_g = val & 16'h7fff;
      REG_STEREO: stereo_g = val[0];
      REG_SCALE: scale_g = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // random burst: mostly loud noise, some small values and extremes
  task automatic random_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) sample_q.push_back($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      else if (r < 3) sample_q.push_back(16'($signed($urandom_range(0, 512)) - 256));
      else sample_q.push_back(16'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    reverb_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes and edge values in mono with reset registers
    for (int i = 0; i < 11; i++) sample_q.push_back(DIRECTED[i]);
    wait_idle();
    // extreme settings, stereo, damping at full scale, ignored index
    write_reg(REG_FEEDBACK, 16'd32112);
    write_reg(REG_DAMPING, 16'd16383);
    write_reg(REG_DRY, 16'd0);
    write_reg(REG_WET, 16'd32767);
    write_reg(REG_STEREO, 16'd1);
    write_reg(REG_SCALE, 16'd65535);
    write_reg(3'd6, 16'hffff);
    write_reg(3'd7, 16'h1234);
    for (int i = 0; i < 12; i++) sample_q.push_back(i[0] ? 16'h8000 : 16'h7fff);
    wait_idle();
    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          write_reg(REG_FEEDBACK, 16'd22937); write_reg(REG_DAMPING, 16'd0);
          write_reg(REG_SCALE, 16'd0); write_reg(REG_STEREO, 16'd0);
        end
        1: begin
          write_reg(REG_FEEDBACK, 16'($urandom_range(22937, 32112)));
          write_reg(REG_DAMPING, 16'($urandom_range(0, 13107)));
          write_reg(REG_DRY, 16'($urandom_range(0, 32767)));
          write_reg(REG_WET, 16'($urandom_range(0, 32767)));
          write_reg(REG_SCALE, 16'($urandom));
          write_reg(REG_STEREO, 16'($urandom_range(0, 1)));
        end
        2: begin
          write_reg(REG_DRY, 16'd32767); write_reg(REG_WET, 16'd0);
          write_reg(REG_SCALE, 16'd65535); write_reg(REG_STEREO, 16'd1);
        end
        default: begin
          write_reg(REG_FEEDBACK, 16'd32112); write_reg(REG_DAMPING, 16'd13107);
          write_reg(REG_WET, 16'd32767); write_reg(REG_SCALE, 16'd24575);
        end
      endcase
      random_burst(100);
    end
    if (n_err == 0) $display("tb_fixed_point_freeverb_reverb_unit: done, clean");
    else $display("tb_fixed_point_freeverb_reverb_unit: done, errors");
    $finish;
  end

  // timeout covering the clearing pass and ~850 words, stalls included
  initial begin
    #30000000;
    $display("tb_fixed_point_freeverb_reverb_unit: done, errors");
    $finish;
  end
endmodule
